@@ sv/ekli_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the energy keyed interpolation block
package ekli_pkg;

   // function codes of an input beat
   localparam logic [1:0] FUNC_HEADER = 2'd0;
   localparam logic [1:0] FUNC_POINT  = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // divider geometry: 16 bit delta times 32 bit delta over a 16 bit span
   localparam int NUM_W     = 48;
   localparam int DEN_W     = 16;
   localparam int DIV_CNT_W = 6;
   localparam int QUO_W     = 32;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         table_sel;
      logic [2:0]         slot;
      logic [6:0]         point_index;
      logic [7:0]         key_energy;
      logic [7:0]         point_count;
      logic signed [15:0] bp_x;
      logic signed [31:0] bp_y;
      logic [7:0]         query_energy;
      logic signed [15:0] query_asym;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               found;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [31:0] y;
   } point_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOT,
      ST_FIRST,
      ST_SCAN,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_FIN,
      ST_DONE
   } state_type;

endpackage

@@ sv/ekli_point_mem.sv @@
`timescale 1ns / 1ps
// breakpoint memory, one write port and one registered read port
module ekli_point_mem import ekli_pkg::*; #(
   parameter int DEPTH  = 3072,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  point_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output point_type         rd_data
);

   point_type mem_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ekli_divider.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ekli_divider import ekli_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W:0]       trial;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ sv/energy_keyed_linear_interpolation.sv @@
`timescale 1ns / 1ps
// sequence: header and point writes are taken in idle; a query to a listed table visits each of its slots
// in ST_SLOT, scans the bins of each matching slot with two or more points, and interpolates each bracket
// throughput: one beat at a time, the breakpoint memory read port sets the scan at one bin
// per cycle and the shared divider works one interpolation at a time (48 quotient bits, done)
// reset: synchronous, clears slot keys and counts and the sequencer; breakpoints are not cleared
module energy_keyed_linear_interpolation import ekli_pkg::*; #(
   parameter int NUM_TABLES = 3,
   parameter int NUM_SLOTS  = 8,
   parameter int MAX_POINTS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // derived sizes
   localparam int NSE    = NUM_TABLES * NUM_SLOTS;
   localparam int SIDX_W = (NSE > 1) ? $clog2(NSE) : 1;
   localparam int SL_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PIDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DEPTH  = NSE * MAX_POINTS;
   localparam int ADDR_W = $clog2(DEPTH);

   // slot headers, cleared by reset
   logic [7:0]       key_ff [NSE];
   logic [CNT_W-1:0] cnt_ff [NSE];

   // sequencer
   state_type state_ff, state_in;
   logic [SL_W-1:0]   i_ff, i_in;        // slot under scan
   logic [PIDX_W-1:0] k_ff, k_in;        // breakpoint index of the word now on the read port
   logic [CNT_W-1:0]  n_ff, n_in;        // point count of the slot under scan
   logic              rsp_valid_ff, rsp_valid_in;

   // query context and datapath registers
   logic [1:0]         tsel_ff, tsel_in;
   logic [7:0]         qe_ff, qe_in;
   logic signed [15:0] qa_ff, qa_in;
   logic signed [15:0] prev_x_ff, prev_x_in;
   logic signed [31:0] prev_y_ff, prev_y_in;
   logic signed [15:0] cur_x_ff, cur_x_in;
   logic signed [31:0] cur_y_ff, cur_y_in;
   logic [15:0]        dx_ff, dx_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [31:0]        dy_mag_ff, dy_mag_in;
   logic               dy_neg_ff, dy_neg_in;
   logic [NUM_W-1:0]   prod_ff, prod_in;
   logic signed [31:0] value_ff, value_in;
   logic               found_ff, found_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memory and divider hookup
   logic              pt_we;
   logic [ADDR_W-1:0] pt_waddr;
   point_type         pt_wdata;
   logic              rd_en;
   logic [PIDX_W-1:0] rd_idx;
   logic [ADDR_W-1:0] rd_addr;
   point_type         rd_pt;
   logic              div_start;
   logic              div_done;
   logic [NUM_W-1:0]  div_quo;

   // header write port
   logic              hdr_we;
   logic [SIDX_W-1:0] hdr_idx;
   logic [CNT_W-1:0]  hdr_cnt;

   logic              req_fire;
   logic [SIDX_W-1:0] s_idx;
   logic              in_bin;
   logic signed [16:0] dx_full;
   logic signed [16:0] den_full;
   logic signed [32:0] dy_full;
   logic signed [33:0] sum_full;
   logic [33:0]        q_term;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // flat slot number of the slot under scan
   assign s_idx   = SIDX_W'(tsel_ff) * SIDX_W'(NUM_SLOTS) + SIDX_W'(i_ff);
   assign rd_addr = ADDR_W'(s_idx) * ADDR_W'(MAX_POINTS) + ADDR_W'(rd_idx);

   // bracket test: previous breakpoint <= asym < current breakpoint
   assign in_bin = (qa_ff >= prev_x_ff) && (qa_ff < rd_pt.x);

   // interpolation differences
   assign dx_full  = {qa_ff[15], qa_ff} - {prev_x_ff[15], prev_x_ff};
   assign den_full = {cur_x_ff[15], cur_x_ff} - {prev_x_ff[15], prev_x_ff};
   assign dy_full  = {cur_y_ff[31], cur_y_ff} - {prev_y_ff[31], prev_y_ff};

   // y1 plus the signed quotient; the result always lands between y1 and y2
   assign q_term   = dy_neg_ff ? (34'd0 - {2'b00, div_quo[QUO_W-1:0]})
                               : {2'b00, div_quo[QUO_W-1:0]};
   assign sum_full = {{2{prev_y_ff[31]}}, prev_y_ff} + $signed(q_term);

   // write decode, only in idle
   always_comb begin
      hdr_we   = req_fire && (req_data.func == FUNC_HEADER)
                 && (int'(req_data.table_sel) < NUM_TABLES)
                 && (int'(req_data.slot) < NUM_SLOTS);
      hdr_idx  = SIDX_W'(req_data.table_sel) * SIDX_W'(NUM_SLOTS) + SIDX_W'(req_data.slot);
      hdr_cnt  = (int'(req_data.point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                            : CNT_W'(req_data.point_count);
      pt_we    = req_fire && (req_data.func == FUNC_POINT)
                 && (int'(req_data.table_sel) < NUM_TABLES)
                 && (int'(req_data.slot) < NUM_SLOTS)
                 && (int'(req_data.point_index) < MAX_POINTS);
      pt_waddr = ADDR_W'(hdr_idx) * ADDR_W'(MAX_POINTS) + ADDR_W'(req_data.point_index);
      pt_wdata = '{x: req_data.bp_x, y: req_data.bp_y};
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      tsel_in      = tsel_ff;
      qe_in        = qe_ff;
      qa_in        = qa_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dx_in        = dx_ff;
      den_in       = den_ff;
      dy_mag_in    = dy_mag_ff;
      dy_neg_in    = dy_neg_ff;
      prod_in      = prod_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      rd_en        = 1'b0;
      rd_idx       = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.func == FUNC_QUERY)) begin
               tsel_in  = req_data.table_sel;
               qe_in    = req_data.query_energy;
               qa_in    = req_data.query_asym;
               value_in = '0;
               found_in = 1'b0;
               i_in     = '0;
               // a table beyond the list answers not found
               state_in = (int'(req_data.table_sel) < NUM_TABLES) ? ST_SLOT : ST_DONE;
            end
         end
         ST_SLOT: begin
            if ((key_ff[s_idx] == qe_ff) && (cnt_ff[s_idx] >= CNT_W'(2))) begin
               n_in     = cnt_ff[s_idx];
               k_in     = '0;
               rd_en    = 1'b1;
               rd_idx   = '0;
               state_in = ST_FIRST;
            end else if (i_ff == SL_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               i_in = i_ff + SL_W'(1);
            end
         end
         ST_FIRST: begin
            // breakpoint zero is on the read port, fetch breakpoint one
            prev_x_in = rd_pt.x;
            prev_y_in = rd_pt.y;
            k_in      = PIDX_W'(1);
            rd_en     = 1'b1;
            rd_idx    = PIDX_W'(1);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (in_bin) begin
               cur_x_in = rd_pt.x;
               cur_y_in = rd_pt.y;
               state_in = ST_PREP;
            end else begin
               prev_x_in = rd_pt.x;
               prev_y_in = rd_pt.y;
               if ((CNT_W'(k_ff) + CNT_W'(1)) < n_ff) begin
                  k_in   = k_ff + PIDX_W'(1);
                  rd_en  = 1'b1;
                  rd_idx = k_ff + PIDX_W'(1);
               end else if (i_ff == SL_W'(NUM_SLOTS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + SL_W'(1);
                  state_in = ST_SLOT;
               end
            end
         end
         ST_PREP: begin
            // offsets are nonnegative and the span positive in a bracketed bin
            dx_in     = dx_full[15:0];
            den_in    = den_full[DEN_W-1:0];
            dy_neg_in = dy_full[32];
            dy_mag_in = dy_full[32] ? 32'(33'd0 - dy_full) : dy_full[31:0];
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = NUM_W'(dx_ff) * NUM_W'(dy_mag_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // later matching slot overrides the earlier answer
            value_in = sum_full[31:0];
            found_in = 1'b1;
            if (i_ff == SL_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + SL_W'(1);
               state_in = ST_SLOT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{value: value_ff, found: found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
      end
   end

   // slot header store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NSE; e++) begin
            key_ff[e] <= '0;
            cnt_ff[e] <= '0;
         end
      end else if (hdr_we) begin
         key_ff[hdr_idx] <= req_data.key_energy;
         cnt_ff[hdr_idx] <= hdr_cnt;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      tsel_ff     <= tsel_in;
      qe_ff       <= qe_in;
      qa_ff       <= qa_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      dx_ff       <= dx_in;
      den_ff      <= den_in;
      dy_mag_ff   <= dy_mag_in;
      dy_neg_ff   <= dy_neg_in;
      prod_ff     <= prod_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
   end

   ekli_point_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_point_mem (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_pt)
   );

   ekli_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the scan never reads past the slot's point count
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(k_ff) < n_ff))
      else $error("breakpoint scan past point count");

   // the divider only finishes while the sequencer waits on it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside wait state");

   // a finished query always lands in the output register
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("query result lost");

   // a miss reports zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.value == 32'sd0))
      else $error("nonzero value without a bracket");

endmodule

@@ sim/energy_keyed_linear_interpolation_tb.sv @@
`timescale 1ns / 1ps
// testbench for the energy keyed interpolation block: predicted answers against result beats
module energy_keyed_linear_interpolation_tb;
   import ekli_pkg::*;

   localparam int TABLES       = 3;
   localparam int SLOTS        = 8;
   localparam int POINTS       = 128;
   localparam int HOLD_CYCLES  = 600;
   localparam int RANDOM_BEATS = 1100;

   // func code the block does not use
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // table numbers
   localparam logic [1:0] TABLE_INNER   = 2'd0;
   localparam logic [1:0] TABLE_OUTER   = 2'd1;
   localparam logic [1:0] TABLE_LEAKAGE = 2'd2;
   localparam logic [1:0] TABLE_NONE    = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // own copy of the correction tables
   logic [7:0]         key_mem   [TABLES][SLOTS];
   int                 count_mem [TABLES][SLOTS];
   logic signed [15:0] x_mem     [TABLES][SLOTS][POINTS];
   logic signed [31:0] y_mem     [TABLES][SLOTS][POINTS];
   bit                 x_loaded  [TABLES][SLOTS][POINTS];

   // answers still owed by the block, oldest first
   rsp_type pending_answers[$];
   rsp_type want;

   int fail_count = 0;
   int beats_sent = 0;
   int hold_req   = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;

   // energies shared by many slots so that queries meet several matches
   logic [7:0] key_pool [6] = '{8'd0, 8'd255, 8'd3, 8'd77, 8'd128, 8'd201};

   energy_keyed_linear_interpolation dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // scan every slot of the table whose key matches; a later bracket wins
   function automatic rsp_type interp_lookup(logic [1:0] t, logic [7:0] e,
                                             logic signed [15:0] a);
      rsp_type r;
      longint  qa, x1, x2, y1, y2, v;
      int      s, j;
      r  = '0;
      qa = a;
      if (t < TABLES) begin
         for (s = 0; s < SLOTS; s++) begin
            if (key_mem[t][s] == e) begin
               for (j = 0; j + 1 < count_mem[t][s]; j++) begin
                  x1 = x_mem[t][s][j];
                  x2 = x_mem[t][s][j + 1];
                  if (qa >= x1 && qa < x2) begin
                     y1 = y_mem[t][s][j];
                     y2 = y_mem[t][s][j + 1];
                     // division truncates toward zero, divisor is positive
                     v  = y1 + ((qa - x1) * (y2 - y1)) / (x2 - x1);
                     r.value = v[31:0];
                     r.found = 1'b1;
                     break;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // update the table copy for one accepted beat, queue the answer of a query
   function automatic void apply_beat(req_type b);
      case (b.func)
         FUNC_HEADER: begin
            // writes to the missing fourth table go nowhere
            if (b.table_sel < TABLES) begin
               key_mem[b.table_sel][b.slot]   = b.key_energy;
               count_mem[b.table_sel][b.slot] = (b.point_count > POINTS) ?
                                                POINTS : int'(b.point_count);
            end
         end
         FUNC_POINT: begin
            if (b.table_sel < TABLES) begin
               x_mem[b.table_sel][b.slot][b.point_index]    = b.bp_x;
               y_mem[b.table_sel][b.slot][b.point_index]    = b.bp_y;
               x_loaded[b.table_sel][b.slot][b.point_index] = 1'b1;
            end
         end
         FUNC_QUERY: begin
            pending_answers.push_back(interp_lookup(b.table_sel, b.query_energy,
                                                    b.query_asym));
         end
         default: begin
            // unused code, no result
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // random fill so that fields the operation ignores still toggle
   function automatic req_type noise_beat();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // one beat on the request side, with an occasional idle cycle in front
   task automatic send_beat(input req_type b);
      if (src_idle_on && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      apply_beat(b);
      beats_sent++;
   endtask

   task automatic put_header(input logic [1:0] t, input logic [2:0] s,
                             input logic [7:0] key, input logic [7:0] cnt);
      req_type b;
      b = noise_beat();
      b.func        = FUNC_HEADER;
      b.table_sel   = t;
      b.slot        = s;
      b.key_energy  = key;
      b.point_count = cnt;
      send_beat(b);
   endtask

   task automatic put_point(input logic [1:0] t, input logic [2:0] s, input logic [6:0] idx,
                            input logic signed [15:0] x, input logic signed [31:0] y);
      req_type b;
      b = noise_beat();
      b.func        = FUNC_POINT;
      b.table_sel   = t;
      b.slot        = s;
      b.point_index = idx;
      b.bp_x        = x;
      b.bp_y        = y;
      send_beat(b);
   endtask

   task automatic ask(input logic [1:0] t, input logic [7:0] e, input logic signed [15:0] a);
      req_type b;
      b = noise_beat();
      b.func         = FUNC_QUERY;
      b.table_sel    = t;
      b.query_energy = e;
      b.query_asym   = a;
      send_beat(b);
   endtask

   // write points 0 .. n-1 of a slot, then its header; x never falls unless unsorted
   task automatic load_slot(input logic [1:0] t, input logic [2:0] s, input int n,
                            input logic [7:0] key, input int cnt, input bit sorted);
      int lo, stepmax, xv, i;
      logic signed [31:0] yv;
      lo      = int'($urandom_range(0, 30000)) - 32768;
      stepmax = (32767 - lo) / n;
      xv      = lo;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) yv = int'($urandom_range(0, 2000000)) - 1000000;
         else yv = $urandom;
         put_point(t, s, 7'(i), sorted ? 16'(xv) : 16'($urandom), yv);
         // zero steps make empty bins now and then
         xv += int'($urandom_range(0, stepmax));
      end
      put_header(t, s, key, 8'(cnt));
   endtask

   // asymmetry inside a bin, on a breakpoint, on a bin top, or anywhere
   function automatic logic signed [15:0] pick_asym(logic [1:0] t, logic [2:0] s);
      int n, j, lo, hi;
      n = count_mem[t][s];
      if (n < 2 || $urandom_range(0, 9) == 0) return 16'($urandom);
      j  = int'($urandom_range(0, n - 2));
      lo = x_mem[t][s][j];
      hi = x_mem[t][s][j + 1];
      if ($urandom_range(0, 7) == 0) return 16'(hi);
      if (hi <= lo + 1 || $urandom_range(0, 3) == 0) return 16'(lo);
      return 16'(lo + int'($urandom_range(0, hi - lo - 1)));
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // freshly reset tables, missing table, unused code
   task automatic test_empty_tables();
      req_type b;
      // every slot matches key zero but has no breakpoints
      ask(TABLE_INNER, 8'd0, 16'sd0);
      ask(TABLE_NONE, 8'd0, 16'sd0);
      b = noise_beat();
      b.func = FUNC_UNUSED;
      send_beat(b);
   endtask

   // bin edges, full-scale values, override by a later slot, short slots
   task automatic test_bracketing_rules();
      put_point(TABLE_INNER, 3'd0, 7'd0, 16'sh8000, 32'sh80000000);
      put_point(TABLE_INNER, 3'd0, 7'd1, 16'sd0,    32'sh7fffffff);
      put_point(TABLE_INNER, 3'd0, 7'd2, 16'sh7fff, 32'sh80000000);
      put_header(TABLE_INNER, 3'd0, 8'd255, 8'd3);
      ask(TABLE_INNER, 8'd255, 16'sh8000);
      ask(TABLE_INNER, 8'd255, -16'sd1);
      ask(TABLE_INNER, 8'd255, 16'sd0);
      ask(TABLE_INNER, 8'd255, 16'sd16384);
      // top of the last bin is outside it
      ask(TABLE_INNER, 8'd255, 16'sh7fff);
      // one point only: brackets nothing, earlier answer stands
      put_point(TABLE_INNER, 3'd1, 7'd0, 16'sh8000, 32'sd5);
      put_header(TABLE_INNER, 3'd1, 8'd255, 8'd1);
      // narrow later slot wins where it brackets
      put_point(TABLE_INNER, 3'd2, 7'd0, -16'sd100, 32'sd1000);
      put_point(TABLE_INNER, 3'd2, 7'd1, 16'sd100,  -32'sd1000);
      put_header(TABLE_INNER, 3'd2, 8'd255, 8'd2);
      ask(TABLE_INNER, 8'd255, 16'sd50);
      ask(TABLE_INNER, 8'd255, 16'sh8000);
      // writes to the missing table are dropped
      put_header(TABLE_NONE, 3'd5, 8'd254, 8'd5);
      put_point(TABLE_NONE, 3'd5, 7'd127, 16'sd1, 32'sd1);
      ask(TABLE_INNER, 8'd254, 16'sd1);
      ask(TABLE_OUTER, 8'd0, 16'sd5);
   endtask

   // a slot with every breakpoint written, count written past the maximum
   task automatic test_full_slot();
      int i;
      load_slot(TABLE_LEAKAGE, 3'd7, POINTS, 8'd0, 255, 1'b1);
      for (i = 0; i < 6; i++) ask(TABLE_LEAKAGE, 8'd0, pick_asym(TABLE_LEAKAGE, 3'd7));
      ask(TABLE_LEAKAGE, 8'd0, 16'sh8000);
      ask(TABLE_LEAKAGE, 8'd0, 16'sh7fff);
      put_header(TABLE_LEAKAGE, 3'd7, 8'd200, 8'd129);
      for (i = 0; i < 4; i++) ask(TABLE_LEAKAGE, 8'd200, pick_asym(TABLE_LEAKAGE, 3'd7));
      put_header(TABLE_LEAKAGE, 3'd7, 8'd200, 8'd128);
      for (i = 0; i < 2; i++) ask(TABLE_LEAKAGE, 8'd200, pick_asym(TABLE_LEAKAGE, 3'd7));
   endtask

   // receiver holds off while queries keep coming, the block must back up
   task automatic test_output_backpressure();
      int i;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      load_slot(TABLE_OUTER, 3'd3, 8, 8'd99, 8, 1'b1);
      hold_req++;
      for (i = 0; i < 20; i++) ask(TABLE_OUTER, 8'd99, pick_asym(TABLE_OUTER, 3'd3));
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // mostly well formed slot loads followed by queries, plus noise
   task automatic test_random_traffic();
      int r, t, s, n, pre, stop;
      logic [7:0] key;
      req_type b;
      stop = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop) begin
         // quiet stretch in the middle, neither side idles
         src_idle_on  = !(beats_sent > stop - 650 && beats_sent < stop - 400);
         sink_idle_on = src_idle_on;
         r   = $urandom_range(0, 99);
         t   = $urandom_range(0, TABLES - 1);
         s   = $urandom_range(0, SLOTS - 1);
         key = ($urandom_range(0, 7) == 0) ? 8'($urandom) : key_pool[$urandom_range(0, 5)];
         if (r < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
            load_slot(2'(t), 3'(s), n, key, n, $urandom_range(0, 9) != 0);
            repeat ($urandom_range(2, 6)) ask(2'(t), key, pick_asym(2'(t), 3'(s)));
         end else if (r < 70) begin
            ask(2'(t), key_mem[t][s], pick_asym(2'(t), 3'(s)));
         end else if (r < 80) begin
            ask(2'($urandom_range(0, 3)), key, 16'($urandom));
         end else if (r < 88) begin
            // header rewrite, count kept within the written prefix of the slot
            pre = 0;
            while (pre < POINTS && x_loaded[t][s][pre]) pre++;
            if (pre == POINTS && $urandom_range(0, 1) == 0) n = $urandom_range(128, 255);
            else n = $urandom_range(0, pre);
            put_header(2'(t), 3'(s), key, 8'(n));
         end else if (r < 91) begin
            put_header(TABLE_NONE, 3'(s), key, 8'($urandom));
         end else if (r < 97) begin
            put_point(2'($urandom_range(0, 3)), 3'(s), 7'($urandom), 16'($urandom), $urandom);
         end else begin
            b = noise_beat();
            b.func = FUNC_UNUSED;
            send_beat(b);
         end
      end
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // ready: long hold on request, else random stalls
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 99) < 12) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // each accepted result against the oldest queued answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: value %0d found %0b",
                        rsp_data.value, rsp_data.found);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.value !== want.value || rsp_data.found !== want.found) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected value %0d found %0b, got value %0d found %0b",
                           want.value, want.found, rsp_data.value, rsp_data.found);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------

   initial begin
      int spins;
      foreach (key_mem[t, s]) begin
         key_mem[t][s]   = '0;
         count_mem[t][s] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_tables();
      test_bracketing_rules();
      test_full_slot();
      test_output_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;

      // drain, then a short tail to catch stray beats
      spins = 0;
      while (pending_answers.size() != 0 && spins < 100000) begin
         @(posedge clock);
         spins++;
      end
      repeat (100) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $display("%0d expected result beats never arrived", pending_answers.size());
         fail_count += pending_answers.size();
      end

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #100000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
